// ===== rtl/core/qfn_pkg.sv =====
// Shared constants for the quaternion follow blender.
// No dependencies; used by the top level of the block.
`default_nettype none
package qfn_pkg;

  localparam int WFRAC   = 30;             // fraction bits of weights and cosine
  localparam int TIME_W  = 16;             // ms fields and follow register
  localparam int ALPHA_W = 17;             // Q1.16 alpha, 0 .. 1.0 inclusive

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_HALF = 17'h08000;

  localparam logic [29:0] K_BASE  = 30'd883471424;   // 0.8227968811988831 in Q30
  localparam logic [29:0] K_SCALE = 30'd628667456;   // 0.5854921936988831 in Q30

endpackage
`default_nettype wire

// ===== rtl/core/qfn_mul.sv =====
// Shared signed multiplier: registered operands, registered product.
// No package dependency.
`default_nettype none
module qfn_mul #(
  parameter int MW = 34
) (
  input  wire logic                   clk,
  input  wire logic                   go,
  input  wire logic signed [MW-1:0]   a,
  input  wire logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0]      p
);

  logic signed [MW-1:0]   a_r;
  logic signed [MW-1:0]   b_r;
  logic signed [2*MW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (go) begin
      a_r <= a;
      b_r <= b;
    end
    p_r <= a_r * b_r;
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/core/qfn_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Divisor must be nonzero. No package dependency.
`default_nettype none
module qfn_div #(
  parameter int DW = 32,
  parameter int VW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DW-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = VW'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[VW-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/qfn_sqrt.sv =====
// Bit-pair integer square root, floor(sqrt(x)), one result bit per cycle.
// NW must be even. No package dependency.
`default_nettype none
module qfn_sqrt #(
  parameter int NW = 34
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] radicand,
  output logic               done,
  output logic [NW-1:0]      root
);

  logic [NW-1:0] x_r, x_nxt;
  logic [NW-1:0] r_r, r_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW-1:0] trial;

  always_comb begin
    x_nxt    = x_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = r_r + b_r;
    if (start) begin
      x_nxt    = radicand;
      r_nxt    = '0;
      b_nxt    = NW'(1) << (NW - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt = b_r >> 2;
      if (b_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign root = r_r;

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_follow_nlerp_unit.sv =====
// Quaternion follow unit: eases a held orientation toward each target word.
// Snap words (first after reset, or follow time zero) go straight from idle to the output stage.
// Blend words run an alpha divide, 39 sequencer steps on the shared multiplier (two dot
// passes, weight, blend, squares), a square root and four normalizing divides, then the
// output stage. One word in flight; ready only when idle. Synchronous active-low reset:
// held = identity, not started, follow time zero.
`default_nettype none
module quaternion_follow_nlerp_unit #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // slave: target_w, target_x, target_y, target_z, elapsed_time_ms (low bits up)
  input  wire logic                                          in_tvalid,
  output logic                                               in_tready,
  input  wire logic [((4*COMPONENT_BITS+16+7)/8)*8-1:0]      in_tdata,
  // master: blended_w, blended_x, blended_y, blended_z (low bits up)
  output logic                                               out_tvalid,
  input  wire logic                                          out_tready,
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]              out_tdata,
  input  wire logic                                          cfg_wr_en,
  input  wire logic [qfn_pkg::TIME_W-1:0]                    cfg_wr_data
);

  localparam int CB  = COMPONENT_BITS;
  localparam int FB  = CB - 1;
  localparam int RW  = CB + 1;
  localparam int AW  = CB + 4;
  localparam int MW  = (CB + 2 > 34) ? CB + 2 : 34;
  localparam int PW  = 2 * MW;
  localparam int NW  = 2 * CB + 2;
  localparam int VW  = CB + 2;
  localparam int DW  = (2 * CB > 32) ? 2 * CB : 32;
  localparam int OTW = ((4 * CB + 7) / 8) * 8;
  localparam int WF  = qfn_pkg::WFRAC;
  localparam int TW  = qfn_pkg::TIME_W;
  localparam int ALW = qfn_pkg::ALPHA_W;
  localparam int CSL = (FB <= WF) ? WF - FB : 0;
  localparam int CSR = (FB > WF) ? FB - WF : 0;

  localparam logic signed [CB-1:0] CMAX   = {1'b0, {FB{1'b1}}};
  localparam logic signed [CB-1:0] CMIN   = {1'b1, {FB{1'b0}}};
  localparam logic signed [MW-1:0] WONE   = MW'(1) << WF;
  localparam logic signed [PW-1:0] RND_W  = PW'(1) << (WF - 1);
  localparam logic signed [PW-1:0] RND_F  = PW'(1) << (FB - 1);
  localparam logic [CB:0]          QONE   = (CB + 1)'(1) << FB;

  // sequencer step marks
  localparam logic [4:0] STP_FLIP  = 5'd6;
  localparam logic [4:0] STP_KBASE = 5'd7;
  localparam logic [4:0] STP_BASE  = 5'd9;
  localparam logic [4:0] STP_KSC   = 5'd11;
  localparam logic [4:0] STP_K     = 5'd13;
  localparam logic [4:0] STP_P1    = 5'd15;
  localparam logic [4:0] STP_P2    = 5'd17;
  localparam logic [4:0] STP_WGT   = 5'd19;
  localparam logic [4:0] STP_BL0   = 5'd20;
  localparam logic [4:0] STP_BL3   = 5'd23;
  localparam logic [4:0] STP_RR0   = 5'd22;
  localparam logic [4:0] STP_RR3   = 5'd25;
  localparam logic [4:0] STP_SQ0   = 5'd26;
  localparam logic [4:0] STP_SQ3   = 5'd29;
  localparam logic [4:0] STP_NN0   = 5'd28;
  localparam logic [4:0] STP_LAST  = 5'd31;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ALPHA = 6'b000010,
    ST_ARITH = 6'b000100,
    ST_ROOT  = 6'b001000,
    ST_NORM  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [4:0]             stp_r, stp_nxt;
  logic                   pass_r, pass_nxt;
  logic [1:0]             ci_r, ci_nxt;
  logic                   started_r, started_nxt;
  logic [TW-1:0]          follow_r;
  logic signed [CB-1:0]   held_r [4];
  logic signed [CB-1:0]   held_nxt [4];
  logic signed [CB-1:0]   tgt_r [4];
  logic signed [CB-1:0]   tgt_nxt [4];
  logic signed [RW-1:0]   rr_r [4];
  logic signed [RW-1:0]   rr_nxt [4];
  logic [ALW-1:0]         alpha_r, alpha_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic signed [MW-1:0]   k_r, k_nxt;
  logic signed [MW-1:0]   wgt_r, wgt_nxt;
  logic [NW-1:0]          n_r, n_nxt;
  logic [VW-1:0]          s_r, s_nxt;
  logic                   ov_r, ov_nxt;
  logic [OTW-1:0]         od_r, od_nxt;

  logic signed [CB-1:0]   tgt_in [4];
  logic [TW-1:0]          elap_in;

  logic                   mul_go;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [PW-1:0]   pw_w, pf_w;
  logic signed [MW-1:0]   p30;
  logic signed [AW-1:0]   pf;

  logic                   div_go, div_done;
  logic [DW-1:0]          div_a, div_q;
  logic [VW-1:0]          div_b;
  logic                   sq_go, sq_done;
  logic [NW-1:0]          sq_root;

  logic [CB-1:0]          dcl;
  logic                   up_half;
  logic [ALW-1:0]         half_t;
  logic signed [MW-1:0]   s30;
  logic signed [MW-1:0]   base;
  logic [1:0]             sel;
  logic [RW-1:0]          mag;
  logic [CB:0]            qc;
  logic signed [CB:0]     negh;
  logic signed [RW-1:0]   rv;

  for (genvar g = 0; g < 4; g++) begin : g_unpack
    assign tgt_in[g] = in_tdata[g*CB +: CB];
  end
  assign elap_in = in_tdata[4*CB +: TW];

  qfn_mul #(.MW(MW)) u_mul (
    .clk (clk), .go (mul_go), .a (mul_a), .b (mul_b), .p (mul_p)
  );

  qfn_div #(.DW(DW), .VW(VW)) u_div (
    .clk (clk), .rst_n (rst_n), .start (div_go), .dividend (div_a),
    .divisor (div_b), .done (div_done), .quotient (div_q)
  );

  // the last quarter square lands in the same cycle as the start
  qfn_sqrt #(.NW(NW)) u_sqrt (
    .clk (clk), .rst_n (rst_n), .start (sq_go), .radicand (n_nxt),
    .done (sq_done), .root (sq_root)
  );

  // round half up of the shared product
  assign pw_w = (mul_p + RND_W) >>> WF;
  assign pf_w = (mul_p + RND_F) >>> FB;
  assign p30  = pw_w[MW-1:0];
  assign pf   = pf_w[AW-1:0];

  // cosine clamp to [0, 1] and the reflected interval
  assign dcl     = (acc_r < 0) ? '0 :
                   (acc_r > AW'(QONE)) ? CB'(QONE) : acc_r[CB-1:0];
  assign up_half = alpha_r > qfn_pkg::ALPHA_HALF;
  assign half_t  = up_half ? qfn_pkg::ALPHA_ONE - alpha_r : alpha_r;
  assign s30     = MW'(half_t) << (WF - 16);
  assign base    = WONE - p30;

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    st_nxt      = st_r;
    stp_nxt     = stp_r;
    pass_nxt    = pass_r;
    ci_nxt      = ci_r;
    started_nxt = started_r;
    alpha_nxt   = alpha_r;
    acc_nxt     = acc_r;
    k_nxt       = k_r;
    wgt_nxt     = wgt_r;
    n_nxt       = n_r;
    s_nxt       = s_r;
    ov_nxt      = ov_r && !out_tready;
    od_nxt      = od_r;
    held_nxt    = held_r;
    tgt_nxt     = tgt_r;
    rr_nxt      = rr_r;
    mul_go      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_go      = 1'b0;
    div_a       = '0;
    div_b       = '0;
    sq_go       = 1'b0;
    sel         = 2'd0;
    mag         = '0;
    qc          = '0;
    negh        = '0;
    rv          = '0;

    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          tgt_nxt = tgt_in;
          if (!started_r || follow_r == '0) begin
            held_nxt    = tgt_in;
            started_nxt = 1'b1;
            st_nxt      = ST_DONE;
          end else begin
            div_go = 1'b1;
            div_a  = DW'({elap_in, 16'h0000});
            div_b  = VW'(follow_r);
            st_nxt = ST_ALPHA;
          end
        end
      end

      ST_ALPHA: begin
        if (div_done) begin
          alpha_nxt = (div_q > DW'(qfn_pkg::ALPHA_ONE)) ? qfn_pkg::ALPHA_ONE
                                                        : div_q[ALW-1:0];
          stp_nxt   = '0;
          pass_nxt  = 1'b0;
          st_nxt    = ST_ARITH;
        end
      end

      ST_ARITH: begin
        stp_nxt = stp_r + 5'd1;
        // two dot products, the second on the hemisphere-corrected held value
        if (stp_r <= 5'd3) begin
          mul_go = 1'b1;
          mul_a  = MW'(held_r[stp_r[1:0]]);
          mul_b  = MW'(tgt_r[stp_r[1:0]]);
        end
        if (stp_r == 5'd0) begin
          acc_nxt = '0;
        end
        if (stp_r >= 5'd2 && stp_r <= 5'd5) begin
          acc_nxt = acc_r + pf;
        end
        if (stp_r == STP_FLIP && !pass_r) begin
          pass_nxt = 1'b1;
          stp_nxt  = '0;
          if (acc_r < 0) begin
            for (int i = 0; i < 4; i++) begin
              negh        = -(CB + 1)'(held_r[i]);
              held_nxt[i] = (held_r[i] == CMIN) ? CMAX : negh[CB-1:0];
            end
          end
        end
        // weight polynomial
        if (stp_r == STP_KBASE) begin
          mul_go = 1'b1;
          mul_a  = MW'(qfn_pkg::K_BASE);
          mul_b  = (MW'(dcl) << CSL) >> CSR;
        end
        if (stp_r == STP_BASE) begin
          mul_go = 1'b1;
          mul_a  = base;
          mul_b  = base;
        end
        if (stp_r == STP_KSC) begin
          mul_go = 1'b1;
          mul_a  = p30;
          mul_b  = MW'(qfn_pkg::K_SCALE);
        end
        if (stp_r == STP_K) begin
          k_nxt  = p30;
          mul_go = 1'b1;
          mul_a  = (s30 <<< 1) - (WONE + (WONE <<< 1));
          mul_b  = p30;
        end
        if (stp_r == STP_P1) begin
          mul_go = 1'b1;
          mul_a  = p30;
          mul_b  = s30;
        end
        if (stp_r == STP_P2) begin
          mul_go = 1'b1;
          mul_a  = p30 + WONE + k_r;
          mul_b  = s30;
        end
        if (stp_r == STP_WGT) begin
          wgt_nxt = up_half ? WONE - p30 : p30;
        end
        // blend, then sum of quarter squares
        if (stp_r >= STP_BL0 && stp_r <= STP_BL3) begin
          sel    = stp_r[1:0];
          mul_go = 1'b1;
          mul_a  = MW'(tgt_r[sel]) - MW'(held_r[sel]);
          mul_b  = wgt_r;
        end
        if (stp_r >= STP_RR0 && stp_r <= STP_RR3) begin
          sel         = stp_r[1:0] + 2'd2;
          rr_nxt[sel] = RW'(held_r[sel]) + p30[RW-1:0];
        end
        if (stp_r >= STP_SQ0 && stp_r <= STP_SQ3) begin
          sel    = stp_r[1:0] + 2'd2;
          mul_go = 1'b1;
          mul_a  = MW'(rr_r[sel]);
          mul_b  = MW'(rr_r[sel]);
        end
        if (stp_r == STP_NN0) begin
          n_nxt = mul_p[NW+1:2];
        end else if (stp_r > STP_NN0) begin
          n_nxt = n_r + mul_p[NW+1:2];
        end
        if (stp_r == STP_LAST) begin
          st_nxt = ST_ROOT;
          sq_go  = 1'b1;
        end
      end

      ST_ROOT: begin
        if (sq_done) begin
          s_nxt = sq_root[VW-1:0];
          if (sq_root == '0) begin
            // zero-length blend goes out unnormalized
            for (int i = 0; i < 4; i++) begin
              held_nxt[i] = (rr_r[i] > RW'(CMAX)) ? CMAX :
                            (rr_r[i] < RW'(CMIN)) ? CMIN : rr_r[i][CB-1:0];
            end
            st_nxt = ST_DONE;
          end else begin
            ci_nxt = 2'd0;
            mag    = rr_r[0][RW-1] ? RW'(-rr_r[0]) : RW'(rr_r[0]);
            div_go = 1'b1;
            div_a  = (DW'(mag) << (FB - 1)) + DW'(sq_root[VW-1:1]);
            div_b  = sq_root[VW-1:0];
            st_nxt = ST_NORM;
          end
        end
      end

      ST_NORM: begin
        if (div_done) begin
          qc = (div_q > DW'(QONE)) ? QONE : div_q[CB:0];
          if (rr_r[ci_r][RW-1]) begin
            held_nxt[ci_r] = CB'(-qc);
          end else begin
            held_nxt[ci_r] = (qc == QONE) ? CMAX : qc[CB-1:0];
          end
          if (ci_r == 2'd3) begin
            st_nxt = ST_DONE;
          end else begin
            ci_nxt = ci_r + 2'd1;
            rv     = rr_r[ci_r + 2'd1];
            mag    = rv[RW-1] ? RW'(-rv) : RW'(rv);
            div_go = 1'b1;
            div_a  = (DW'(mag) << (FB - 1)) + DW'(s_r[VW-1:1]);
            div_b  = s_r;
          end
        end
      end

      ST_DONE: begin
        if (!ov_r || out_tready) begin
          od_nxt = '0;
          for (int i = 0; i < 4; i++) begin
            od_nxt[i*CB +: CB] = held_r[i];
          end
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      stp_r     <= '0;
      pass_r    <= 1'b0;
      ci_r      <= '0;
      started_r <= 1'b0;
      follow_r  <= '0;
      ov_r      <= 1'b0;
      held_r[0] <= CMAX;
      held_r[1] <= '0;
      held_r[2] <= '0;
      held_r[3] <= '0;
    end else begin
      st_r      <= st_nxt;
      stp_r     <= stp_nxt;
      pass_r    <= pass_nxt;
      ci_r      <= ci_nxt;
      started_r <= started_nxt;
      ov_r      <= ov_nxt;
      held_r    <= held_nxt;
      if (cfg_wr_en) begin
        follow_r <= cfg_wr_data;
      end
    end
    tgt_r   <= tgt_nxt;
    rr_r    <= rr_nxt;
    alpha_r <= alpha_nxt;
    acc_r   <= acc_nxt;
    k_r     <= k_nxt;
    wgt_r   <= wgt_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    od_r    <= od_nxt;
  end

endmodule
`default_nettype wire
